### rtl/core/hcrg_pkg.sv
package hcrg_pkg;

   // Field widths of the transactions and of the speed register.
   localparam int ELAPSED_W = 16;
   localparam int SPEED_W   = 12;
   localparam int COLOR_W   = 8;
   localparam int HUE_W     = 19;

   // Advance in millidegrees: speed times elapsed, at most 4095 * 65535.
   localparam int ADV_W = SPEED_W + ELAPSED_W;

   // Configuration port.
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(60);
   localparam logic               CSR_IDX_SPEED = 1'b0;

   // Hue circle constants in millidegrees.
   localparam logic [HUE_W-1:0] HUE_FULL    = HUE_W'(360000);
   localparam logic [HUE_W-1:0] SECTOR_SPAN = HUE_W'(60000);
   localparam logic [HUE_W-1:0] HALF_SPAN   = HUE_W'(30000);

   // advance / 360000 as (advance * RECIP_FULL) >> FULL_SHIFT, exact for all
   // advance values of ADV_W bits.
   localparam int FULL_SHIFT = 48;
   localparam int RECIP_FULL_W = 30;
   localparam logic [RECIP_FULL_W-1:0] RECIP_FULL = RECIP_FULL_W'(781874936);
   localparam int FULL_PROD_W = ADV_W + RECIP_FULL_W;
   localparam int FULL_QUOT_W = 10;

   // ramp numerator / 60000 as (v * RECIP_SPAN) >> SPAN_SHIFT, exact for
   // numerators up to 60000 * 255 + 30000.
   localparam int RAMP_T_W   = 16;
   localparam int RAMP_NUM_W = 24;
   localparam int SPAN_SHIFT = 40;
   localparam int RECIP_SPAN_W = 25;
   localparam logic [RECIP_SPAN_W-1:0] RECIP_SPAN = RECIP_SPAN_W'(18325194);
   localparam int SPAN_PROD_W = RAMP_NUM_W + RECIP_SPAN_W;

   localparam logic [COLOR_W-1:0] COLOR_FULL = '1;
   localparam logic [COLOR_W-1:0] COLOR_NONE = '0;

   // Queue between the front and the back.
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);

   typedef enum logic [2:0] {
      SECTOR_RED_GREEN_UP   = 3'd0,
      SECTOR_GREEN_RED_DOWN = 3'd1,
      SECTOR_GREEN_BLUE_UP  = 3'd2,
      SECTOR_BLUE_GREEN_DOWN = 3'd3,
      SECTOR_BLUE_RED_UP    = 3'd4,
      SECTOR_RED_BLUE_DOWN  = 3'd5
   } sector_type;

   typedef struct packed {
      logic             restart;
      logic [ADV_W-1:0] advance;
   } job_type;

   typedef struct packed {
      logic full;
      logic head_valid;
   } qstat_type;

endpackage

### rtl/core/hcrg_if.sv
interface hcrg_req_if;
   logic                           valid;
   logic                           ready;
   logic [hcrg_pkg::ELAPSED_W-1:0] elapsed_ms;
   logic                           restart;

   modport source (output valid, output elapsed_ms, output restart, input ready);
   modport sink   (input valid, input elapsed_ms, input restart, output ready);
endinterface

interface hcrg_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hcrg_pkg::COLOR_W-1:0] red;
   logic [hcrg_pkg::COLOR_W-1:0] green;
   logic [hcrg_pkg::COLOR_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### rtl/core/hcrg_csr.sv
module hcrg_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [hcrg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [hcrg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [hcrg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready,
   output logic [hcrg_pkg::SPEED_W-1:0]    speed
);

   logic [hcrg_pkg::SPEED_W-1:0] speed_ff;
   logic                         reg_idx;
   logic                         wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= hcrg_pkg::SPEED_RESET;
      end else if (wr_en && (reg_idx == hcrg_pkg::CSR_IDX_SPEED)) begin
         speed_ff <= csr_pwdata[hcrg_pkg::SPEED_W-1:0];
      end
   end

   always_comb begin
      if (reg_idx == hcrg_pkg::CSR_IDX_SPEED) begin
         csr_prdata = {{(hcrg_pkg::CSR_DATA_W - hcrg_pkg::SPEED_W){1'b0}}, speed_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   assign speed = speed_ff;

endmodule

### rtl/core/hcrg_front.sv
module hcrg_front (
   hcrg_req_if.sink                      req,
   input  logic [hcrg_pkg::SPEED_W-1:0]  speed,
   input  hcrg_pkg::qstat_type           qstat,
   output logic                          push_valid,
   output hcrg_pkg::job_type             push_job
);

   // A restart needs no advance; the back clears the hue instead.
   assign req.ready  = !qstat.full;
   assign push_valid = req.valid && !qstat.full;

   always_comb begin
      push_job.restart = req.restart;
      if (req.restart) begin
         push_job.advance = '0;
      end else begin
         push_job.advance = hcrg_pkg::ADV_W'(speed * req.elapsed_ms);
      end
   end

endmodule

### rtl/core/hcrg_queue.sv
module hcrg_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  hcrg_pkg::job_type   push_job,
   input  logic                pop,
   output hcrg_pkg::qstat_type qstat,
   output hcrg_pkg::job_type   head_job
);

   hcrg_pkg::job_type          entries_ff [hcrg_pkg::Q_DEPTH];
   logic [hcrg_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [hcrg_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [hcrg_pkg::Q_PTR_W:0]   count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;

   assign qstat.full       = (count_ff == (hcrg_pkg::Q_PTR_W+1)'(hcrg_pkg::Q_DEPTH));
   assign qstat.head_valid = (count_ff != '0);
   assign do_push = push_valid && !qstat.full;
   assign do_pop  = pop && qstat.head_valid;
   assign head_job = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### rtl/core/hcrg_back.sv
module hcrg_back (
   input  logic                clock,
   input  logic                reset,
   input  hcrg_pkg::qstat_type qstat,
   input  hcrg_pkg::job_type   head_job,
   output logic                pop,
   hcrg_rsp_if.source          rsp
);

   // Stage valids; the whole line moves when the output slot is free.
   logic advance_en;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;

   // Stage 1: quotient product of the advance.
   logic [hcrg_pkg::FULL_PROD_W-1:0] prod1_ff;
   logic [hcrg_pkg::ADV_W-1:0]       adv1_ff;
   logic                             rst1_ff;

   // Stage 2: advance modulo a full turn.
   logic [hcrg_pkg::FULL_QUOT_W-1:0] quot2;
   logic [hcrg_pkg::ADV_W:0]         rem2;
   logic [hcrg_pkg::HUE_W-1:0]       rem2_ff;
   logic                             rst2_ff;

   // Stage 3: the hue accumulator.
   logic [hcrg_pkg::HUE_W:0]   hue_sum;
   logic [hcrg_pkg::HUE_W-1:0] hue_ff, hue_in;

   // Stage 4: sector and ramp distance.
   hcrg_pkg::sector_type          sector4;
   logic [hcrg_pkg::HUE_W-1:0]    base4;
   logic [hcrg_pkg::RAMP_T_W-1:0] frac4;
   hcrg_pkg::sector_type          sector4_ff;
   logic [hcrg_pkg::RAMP_T_W-1:0] t4_ff;

   // Stage 5: rounded ramp product.
   logic [hcrg_pkg::RAMP_NUM_W-1:0]  num5;
   logic [hcrg_pkg::SPAN_PROD_W-1:0] prod5_ff;
   hcrg_pkg::sector_type             sector5_ff;

   // Stage 6: output register.
   logic [hcrg_pkg::COLOR_W-1:0] ramp6;
   logic [hcrg_pkg::COLOR_W-1:0] red_ff, green_ff, blue_ff;

   assign advance_en = !v6_ff || rsp.ready;
   assign pop        = advance_en && qstat.head_valid;

   assign quot2 = prod1_ff[hcrg_pkg::FULL_SHIFT +: hcrg_pkg::FULL_QUOT_W];
   assign rem2  = (hcrg_pkg::ADV_W+1)'(adv1_ff)
                - (hcrg_pkg::ADV_W+1)'(quot2 * hcrg_pkg::HUE_FULL);

   always_comb begin
      hue_sum = {1'b0, hue_ff} + {1'b0, rem2_ff};
      if (rst2_ff) begin
         hue_in = '0;
      end else if (hue_sum >= {1'b0, hcrg_pkg::HUE_FULL}) begin
         hue_in = hcrg_pkg::HUE_W'(hue_sum - {1'b0, hcrg_pkg::HUE_FULL});
      end else begin
         hue_in = hue_sum[hcrg_pkg::HUE_W-1:0];
      end
   end

   always_comb begin
      priority if (hue_ff >= hcrg_pkg::HUE_W'(300000)) begin
         sector4 = hcrg_pkg::SECTOR_RED_BLUE_DOWN;
         base4   = hcrg_pkg::HUE_W'(300000);
      end else if (hue_ff >= hcrg_pkg::HUE_W'(240000)) begin
         sector4 = hcrg_pkg::SECTOR_BLUE_RED_UP;
         base4   = hcrg_pkg::HUE_W'(240000);
      end else if (hue_ff >= hcrg_pkg::HUE_W'(180000)) begin
         sector4 = hcrg_pkg::SECTOR_BLUE_GREEN_DOWN;
         base4   = hcrg_pkg::HUE_W'(180000);
      end else if (hue_ff >= hcrg_pkg::HUE_W'(120000)) begin
         sector4 = hcrg_pkg::SECTOR_GREEN_BLUE_UP;
         base4   = hcrg_pkg::HUE_W'(120000);
      end else if (hue_ff >= hcrg_pkg::SECTOR_SPAN) begin
         sector4 = hcrg_pkg::SECTOR_GREEN_RED_DOWN;
         base4   = hcrg_pkg::SECTOR_SPAN;
      end else begin
         sector4 = hcrg_pkg::SECTOR_RED_GREEN_UP;
         base4   = '0;
      end
      frac4 = hcrg_pkg::RAMP_T_W'(hue_ff - base4);
   end

   // t * 255 + 30000, with the constant product written as a shift and a subtraction.
   assign num5 = (hcrg_pkg::RAMP_NUM_W'(t4_ff) << 8) - hcrg_pkg::RAMP_NUM_W'(t4_ff)
               + hcrg_pkg::RAMP_NUM_W'(hcrg_pkg::HALF_SPAN);
   assign ramp6 = prod5_ff[hcrg_pkg::SPAN_SHIFT +: hcrg_pkg::COLOR_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         hue_ff <= '0;
      end else if (advance_en) begin
         v1_ff <= qstat.head_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         if (v2_ff) begin
            hue_ff <= hue_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance_en) begin
         prod1_ff <= hcrg_pkg::FULL_PROD_W'(head_job.advance * hcrg_pkg::RECIP_FULL);
         adv1_ff  <= head_job.advance;
         rst1_ff  <= head_job.restart;

         rem2_ff <= rem2[hcrg_pkg::HUE_W-1:0];
         rst2_ff <= rst1_ff;

         sector4_ff <= sector4;
         if (sector4[0]) begin
            t4_ff <= hcrg_pkg::RAMP_T_W'(hcrg_pkg::SECTOR_SPAN) - frac4;
         end else begin
            t4_ff <= frac4;
         end

         prod5_ff   <= hcrg_pkg::SPAN_PROD_W'(num5 * hcrg_pkg::RECIP_SPAN);
         sector5_ff <= sector4_ff;

         unique case (sector5_ff)
            hcrg_pkg::SECTOR_RED_GREEN_UP: begin
               red_ff <= hcrg_pkg::COLOR_FULL; green_ff <= ramp6; blue_ff <= hcrg_pkg::COLOR_NONE;
            end
            hcrg_pkg::SECTOR_GREEN_RED_DOWN: begin
               red_ff <= ramp6; green_ff <= hcrg_pkg::COLOR_FULL; blue_ff <= hcrg_pkg::COLOR_NONE;
            end
            hcrg_pkg::SECTOR_GREEN_BLUE_UP: begin
               red_ff <= hcrg_pkg::COLOR_NONE; green_ff <= hcrg_pkg::COLOR_FULL; blue_ff <= ramp6;
            end
            hcrg_pkg::SECTOR_BLUE_GREEN_DOWN: begin
               red_ff <= hcrg_pkg::COLOR_NONE; green_ff <= ramp6; blue_ff <= hcrg_pkg::COLOR_FULL;
            end
            hcrg_pkg::SECTOR_BLUE_RED_UP: begin
               red_ff <= ramp6; green_ff <= hcrg_pkg::COLOR_NONE; blue_ff <= hcrg_pkg::COLOR_FULL;
            end
            default: begin
               red_ff <= hcrg_pkg::COLOR_FULL; green_ff <= hcrg_pkg::COLOR_NONE; blue_ff <= ramp6;
            end
         endcase
      end
   end

   assign rsp.valid = v6_ff;
   assign rsp.red   = red_ff;
   assign rsp.green = green_ff;
   assign rsp.blue  = blue_ff;

   // The hue never leaves one turn.
   a_hue_range : assert property (@(posedge clock) disable iff (reset)
      hue_ff < hcrg_pkg::HUE_FULL)
      else $error("hue accumulator out of range");

   // A restart that reaches the accumulator clears it.
   a_restart_clears : assert property (@(posedge clock) disable iff (reset)
      (advance_en && v2_ff && rst2_ff) |=> (hue_ff == '0))
      else $error("restart did not clear the hue");

   // A fully saturated color always has one channel at full scale.
   a_full_channel : assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (red_ff == hcrg_pkg::COLOR_FULL || green_ff == hcrg_pkg::COLOR_FULL
                     || blue_ff == hcrg_pkg::COLOR_FULL))
      else $error("no channel at full scale");

   // The line does not move while a result waits to be taken.
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      (v6_ff && !rsp.ready) |-> !pop)
      else $error("queue popped during output stall");

endmodule

### rtl/core/hue_cycle_rgb_generator_core.sv
// Color-cycling generator with a valid/ready request and response channel.
// Each request transaction carries elapsed_ms and restart; each one yields
// exactly one response transaction with red, green and blue, in order.
// The hue advances by speed_dps * elapsed_ms millidegrees per transaction,
// modulo a full turn, or returns to zero on restart. speed_dps sits at byte
// address 0 of the APB-style port and resets to 60 degrees per second.
// Throughput is one transaction per cycle while rsp.ready stays high: the
// hue accumulator is the only loop and closes through its own register;
// the two reciprocal multipliers are pipelined.
// Reset clears the hue, the queue and every pipeline valid; the speed
// register returns to its reset value.
// When the receiver stalls, the back pipeline freezes as a whole, the
// four-entry queue fills, and req.ready drops once it is full.
module hue_cycle_rgb_generator_core (
   input  logic                            clock,
   input  logic                            reset,
   hcrg_req_if.sink                        req,
   hcrg_rsp_if.source                      rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [hcrg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [hcrg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [hcrg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   // Current speed from the register block.
   logic [hcrg_pkg::SPEED_W-1:0] speed;

   // The front turns each request into a job: restart flag and advance.
   logic                push_valid;
   hcrg_pkg::job_type   push_job;

   // The queue decouples acceptance from the back pipeline.
   hcrg_pkg::qstat_type qstat;
   hcrg_pkg::job_type   head_job;
   logic                pop;

   hcrg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .speed       (speed)
   );

   hcrg_front u_front (
      .req        (req),
      .speed      (speed),
      .qstat      (qstat),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   hcrg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop        (pop),
      .qstat      (qstat),
      .head_job   (head_job)
   );

   // The back reduces the advance, updates the hue and builds the color.
   hcrg_back u_back (
      .clock    (clock),
      .reset    (reset),
      .qstat    (qstat),
      .head_job (head_job),
      .pop      (pop),
      .rsp      (rsp)
   );

endmodule
